[rtl/polyphonic_wavetable_voice_engine_macros.svh]
// shared assertion macros
`ifndef POLYPHONIC_WAVETABLE_VOICE_ENGINE_MACROS_SVH
`define POLYPHONIC_WAVETABLE_VOICE_ENGINE_MACROS_SVH

// condition holds in the same cycle
`define PWVE_ASSERT_SAME(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);

// condition holds in the next cycle
`define PWVE_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);

`endif

[rtl/pwve_pkg.sv]
`timescale 1ns / 1ps
package pwve_pkg;

    localparam int VOICES     = 8;
    localparam int TABLE_SIZE = 256;
    localparam int WAVE_COUNT = 4;
    localparam int FADE_STEPS = 8;

    localparam logic [15:0] NOISE_SEED     = 16'hACE1;
    localparam logic [1:0]  NOISE_WAVE_RST = 2'd1;
    localparam int          DAC_OFFSET     = 2048;
    localparam int          DAC_MAX        = 4095;

    localparam logic [2:0] FN_TICK      = 3'd0;
    localparam logic [2:0] FN_NOTE_ON   = 3'd1;
    localparam logic [2:0] FN_NOTE_AUTO = 3'd2;
    localparam logic [2:0] FN_NOTE_OFF  = 3'd3;
    localparam logic [2:0] FN_GROUP_OFF = 3'd4;
    localparam logic [2:0] FN_TABLE_WR  = 3'd5;

    localparam logic CFG_PORTA = 1'b0;
    localparam logic CFG_NOISE = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK_INIT,
        OP_GLIDE,
        OP_PHASE,
        OP_RD0,
        OP_RD1,
        OP_INTERP,
        OP_MUL1,
        OP_MUL2,
        OP_ACC,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_PICK,
        OP_NOTE_SEL,
        OP_NOTE_START,
        OP_NOTE_END,
        OP_NOTE_OFF,
        OP_GROUP_OFF,
        OP_TABLE_WR,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ptr_inc;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       voice_active;
        logic       voice_drop;
        logic       last_voice;
        logic       note_ok;
        logic       glide_div;
        logic       div_done;
        logic       out_busy;
    } t_sts;

    // index bits taken from the top of the phase
    function automatic int table_bits(int ts);
        int b;
        b = 0;
        for (int k = 0; k < 12; k++) begin
            if ((2 << k) <= ts) b = k + 1;
        end
        return b;
    endfunction

endpackage

[rtl/pwve_div.sv]
`timescale 1ns / 1ps
module pwve_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [19:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [19:0] r_div, n_div;
    logic [20:0] w_trial;
    logic        w_fit;

    // restoring division, one quotient bit a cycle
    assign w_trial = {r_rem, r_quo[31]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? 20'(w_trial - {1'b0, r_div}) : w_trial[19:0];
            n_quo = {r_quo[30:0], w_fit};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[rtl/pwve_dp.sv]
`timescale 1ns / 1ps
module pwve_dp #(
    parameter int VOICES     = pwve_pkg::VOICES,
    parameter int TABLE_SIZE = pwve_pkg::TABLE_SIZE,
    parameter int WAVE_COUNT = pwve_pkg::WAVE_COUNT,
    parameter int FADE_STEPS = pwve_pkg::FADE_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwve_pkg::t_cmd     i_cmd,
    output pwve_pkg::t_sts     o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    input  logic [2:0]         i_func,
    input  logic [2:0]         i_voice,
    input  logic [31:0]        i_phase_increment,
    input  logic [11:0]        i_amplitude,
    input  logic [1:0]         i_wave,
    input  logic [7:0]         i_group_id,
    input  logic [9:0]         i_table_address,
    input  logic signed [12:0] i_table_value,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_is_sample,
    output logic [11:0]        o_dac_value,
    output logic [2:0]         o_voice_index
);

    localparam int VW    = $clog2(VOICES);
    localparam int FW    = $clog2(FADE_STEPS + 1);
    localparam int TB    = pwve_pkg::table_bits(TABLE_SIZE);
    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int DEPTH = WAVE_COUNT * TABLE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int MIX_W = 16 + $clog2(VOICES);
    localparam logic signed [MIX_W:0] MIX_OFFS = (MIX_W + 1)'(pwve_pkg::DAC_OFFSET);
    localparam logic signed [MIX_W:0] MIX_TOP  = (MIX_W + 1)'(pwve_pkg::DAC_MAX);

    // latched transaction
    logic [2:0]         r_func;
    logic [2:0]         r_voice;
    logic [31:0]        r_inc;
    logic [11:0]        r_amp;
    logic [1:0]         r_wave;
    logic [7:0]         r_grp;
    logic [9:0]         r_taddr;
    logic signed [12:0] r_tval;

    logic [19:0] r_porta;
    logic [1:0]  r_noise_wave;

    // voice bank
    logic              r_active  [VOICES];
    logic              r_fading  [VOICES];
    logic [FW-1:0]     r_fade    [VOICES];
    logic [31:0]       r_phase   [VOICES];
    logic [31:0]       r_vinc    [VOICES];
    logic [31:0]       r_target  [VOICES];
    logic signed [31:0] r_step   [VOICES];
    logic [11:0]       r_vamp    [VOICES];
    logic [1:0]        r_vwave   [VOICES];
    logic [31:0]       r_birth   [VOICES];
    logic [7:0]        r_group   [VOICES];

    logic [VW-1:0] r_ptr;
    logic [VW-1:0] r_nvoice;
    logic [15:0]   r_noise;
    logic [31:0]   r_age;

    logic signed [MIX_W-1:0] r_mix;
    logic signed [12:0]      r_s0;
    logic signed [12:0]      r_smp;
    logic signed [24:0]      r_p1;
    logic signed [14:0]      r_p2;

    logic          r_free_ok, r_fbest_ok;
    logic [VW-1:0] r_free, r_fbest, r_old;
    logic [FW-1:0] r_minfade;
    logic [31:0]   r_oldbirth;

    logic r_dsign, r_dnz;

    logic signed [12:0] r_mem [DEPTH];
    logic signed [12:0] r_rdata;

    logic        r_out_valid;
    logic        r_out_is;
    logic [11:0] r_out_dac;
    logic [2:0]  r_out_vi;

    // current voice view
    logic [VW-1:0]      w_vi;
    logic               w_act, w_fad, w_noise;
    logic [FW-1:0]      w_fade;
    logic [31:0]        w_phase, w_vinc, w_target;
    logic signed [31:0] w_step;
    logic [1:0]         w_wave;

    assign w_vi = (i_cmd.op == pwve_pkg::OP_NOTE_START || i_cmd.op == pwve_pkg::OP_NOTE_END)
                  ? r_nvoice : r_ptr;
    assign w_act    = r_active[w_vi];
    assign w_fad    = r_fading[w_vi];
    assign w_fade   = r_fade[w_vi];
    assign w_phase  = r_phase[w_vi];
    assign w_vinc   = r_vinc[w_vi];
    assign w_target = r_target[w_vi];
    assign w_step   = r_step[w_vi];
    assign w_wave   = r_vwave[w_vi];
    assign w_noise  = w_wave == r_noise_wave;

    // glide
    logic signed [31:0] w_rem;
    logic               w_arrived;
    assign w_rem     = $signed(w_target - w_vinc);
    assign w_arrived = (w_step > 0) ? (w_rem <= w_step) : (w_rem >= w_step);

    logic w_drop;
    assign w_drop = w_fad && (w_fade == '0);

    // xorshift noise
    logic [15:0]        w_n1, w_n2, w_n3;
    logic signed [12:0] w_nsmp;
    assign w_n1   = r_noise ^ (r_noise >> 1);
    assign w_n2   = w_n1 ^ (w_n1 << 5);
    assign w_n3   = w_n2 ^ (w_n2 >> 14);
    assign w_nsmp = $signed({1'b0, w_n3[11:0]}) - 13'sd2048;

    // table addressing
    logic [IW-1:0] w_i0, w_i1;
    logic [7:0]    w_frac;
    logic [AW-1:0] w_a0, w_a1, w_raddr;
    logic          w_wave_ok;
    assign w_i0   = IW'(w_phase[31 -: TB]);
    assign w_i1   = (32'(w_i0) + 32'd1 == TABLE_SIZE) ? '0 : w_i0 + IW'(1);
    assign w_frac = w_phase[31 - TB -: 8];
    assign w_a0   = AW'(32'(w_wave) * TABLE_SIZE + 32'(w_i0));
    assign w_a1   = AW'(32'(w_wave) * TABLE_SIZE + 32'(w_i1));
    assign w_raddr = (i_cmd.op == pwve_pkg::OP_RD1) ? w_a1 : w_a0;
    assign w_wave_ok = 32'(w_wave) < WAVE_COUNT;

    // interpolation
    logic signed [13:0] w_d;
    logic signed [22:0] w_dm;
    logic signed [12:0] w_interp;
    assign w_d      = 14'(r_rdata) - 14'(r_s0);
    assign w_dm     = w_d * $signed({1'b0, w_frac});
    assign w_interp = r_s0 + 13'(w_dm >>> 8);

    logic signed [25+FW:0] w_p2f;
    assign w_p2f = r_p1 * $signed({1'b0, w_fade});

    // note start
    logic        w_glide;
    logic [31:0] w_diff, w_mag;
    assign w_glide = (r_porta != '0) && r_active[r_nvoice] && !r_fading[r_nvoice];
    assign w_diff  = r_inc - r_vinc[r_nvoice];
    assign w_mag   = w_diff[31] ? (32'd0 - w_diff) : w_diff;

    logic        w_div_start, w_div_done;
    logic [31:0] w_quot;
    logic signed [31:0] w_newstep;
    assign w_div_start = (i_cmd.op == pwve_pkg::OP_NOTE_START) && w_glide && (r_porta > 20'd1);
    assign w_newstep = (w_quot == '0) ? (r_dnz ? (r_dsign ? -32'sd1 : 32'sd1) : 32'sd0)
                                      : (r_dsign ? -$signed(w_quot) : $signed(w_quot));

    pwve_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_mag),
        .i_divisor (r_porta),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    logic          w_note_ok;
    logic [VW-1:0] w_vsel;
    assign w_note_ok = 32'(r_voice) < VOICES;
    assign w_vsel    = VW'(r_voice);

    logic w_last;
    assign w_last = 32'(r_ptr) == VOICES - 1;

    // output shaping
    logic signed [MIX_W:0] w_sum;
    logic [11:0]           w_dac;
    assign w_sum = {r_mix[MIX_W-1], r_mix} + MIX_OFFS;
    always_comb begin
        if (w_sum < 0)
            w_dac = '0;
        else if (w_sum > MIX_TOP)
            w_dac = 12'(pwve_pkg::DAC_MAX);
        else
            w_dac = w_sum[11:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_active[v] <= 1'b0;
                r_fading[v] <= 1'b0;
            end
            r_ptr        <= '0;
            r_noise      <= pwve_pkg::NOISE_SEED;
            r_age        <= '0;
            r_porta      <= '0;
            r_noise_wave <= pwve_pkg::NOISE_WAVE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pwve_pkg::CFG_PORTA: r_porta <= i_cfg_data;
                    pwve_pkg::CFG_NOISE: r_noise_wave <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_cmd.ptr_inc) begin
                r_ptr <= w_last ? '0 : r_ptr + VW'(1);
            end
            unique case (i_cmd.op)
                pwve_pkg::OP_TICK_INIT, pwve_pkg::OP_SCAN_INIT: r_ptr <= '0;
                pwve_pkg::OP_PHASE: begin
                    if (w_act && w_drop) begin
                        r_active[w_vi] <= 1'b0;
                        if (w_noise) r_noise <= w_n3;
                    end
                end
                pwve_pkg::OP_RD0: begin
                    if (w_noise) r_noise <= w_n3;
                end
                pwve_pkg::OP_NOTE_START: begin
                    r_fading[w_vi] <= 1'b0;
                    r_active[w_vi] <= 1'b1;
                    r_age          <= r_age + 32'd1;
                end
                pwve_pkg::OP_NOTE_OFF: begin
                    if (w_note_ok && r_active[w_vsel] && !r_fading[w_vsel])
                        r_fading[w_vsel] <= 1'b1;
                end
                pwve_pkg::OP_GROUP_OFF: begin
                    if (r_grp != '0) begin
                        for (int v = 0; v < VOICES; v++) begin
                            if (r_active[v] && !r_fading[v] && r_group[v] == r_grp)
                                r_fading[v] <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (i_cmd.op == pwve_pkg::OP_OUT)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pwve_pkg::OP_LOAD: begin
                r_func  <= i_func;
                r_voice <= i_voice;
                r_inc   <= i_phase_increment;
                r_amp   <= i_amplitude;
                r_wave  <= i_wave;
                r_grp   <= i_group_id;
                r_taddr <= i_table_address;
                r_tval  <= i_table_value;
            end
            pwve_pkg::OP_TICK_INIT: r_mix <= '0;
            pwve_pkg::OP_GLIDE: begin
                if (w_act && w_step != 0) begin
                    if (w_arrived) begin
                        r_vinc[w_vi] <= w_target;
                        r_step[w_vi] <= '0;
                    end else begin
                        r_vinc[w_vi] <= w_vinc + w_step;
                    end
                end
            end
            pwve_pkg::OP_PHASE: begin
                r_phase[w_vi] <= w_phase + w_vinc;
                if (w_fad) begin
                    if (w_fade != '0) r_fade[w_vi] <= w_fade - FW'(1);
                end else if (w_fade < FW'(FADE_STEPS)) begin
                    r_fade[w_vi] <= w_fade + FW'(1);
                end
            end
            pwve_pkg::OP_RD0: begin
                if (w_noise) r_smp <= w_nsmp;
            end
            pwve_pkg::OP_RD1: r_s0 <= r_rdata;
            pwve_pkg::OP_INTERP: begin
                if (!w_noise) r_smp <= w_wave_ok ? w_interp : '0;
            end
            pwve_pkg::OP_MUL1: r_p1 <= 25'(r_smp * $signed({1'b0, r_vamp[w_vi]}));
            pwve_pkg::OP_MUL2: r_p2 <= 15'(w_p2f >>> 15);
            pwve_pkg::OP_ACC:  r_mix <= r_mix + MIX_W'(r_p2);
            pwve_pkg::OP_SCAN_INIT: begin
                r_free_ok  <= 1'b0;
                r_fbest_ok <= 1'b0;
            end
            pwve_pkg::OP_SCAN: begin
                if (!w_act && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free    <= r_ptr;
                end
                if (w_fad && (!r_fbest_ok || w_fade < r_minfade)) begin
                    r_fbest_ok <= 1'b1;
                    r_fbest    <= r_ptr;
                    r_minfade  <= w_fade;
                end
                if (r_ptr == '0 || r_birth[w_vi] < r_oldbirth) begin
                    r_old      <= r_ptr;
                    r_oldbirth <= r_birth[w_vi];
                end
            end
            pwve_pkg::OP_PICK: begin
                r_nvoice <= r_free_ok ? r_free : (r_fbest_ok ? r_fbest : r_old);
            end
            pwve_pkg::OP_NOTE_SEL: r_nvoice <= w_vsel;
            pwve_pkg::OP_NOTE_START: begin
                if (w_glide) begin
                    r_target[w_vi] <= r_inc;
                    if (r_porta == 20'd1) begin
                        r_vinc[w_vi] <= r_inc;
                        r_step[w_vi] <= '0;
                    end
                end else begin
                    r_vinc[w_vi]   <= r_inc;
                    r_target[w_vi] <= r_inc;
                    r_step[w_vi]   <= '0;
                    r_phase[w_vi]  <= '0;
                end
                r_dsign       <= w_diff[31];
                r_dnz         <= w_diff != '0;
                r_vamp[w_vi]  <= r_amp;
                r_vwave[w_vi] <= r_wave;
                r_fade[w_vi]  <= '0;
                r_birth[w_vi] <= r_age;
                r_group[w_vi] <= r_grp;
            end
            pwve_pkg::OP_NOTE_END: r_step[w_vi] <= w_newstep;
            pwve_pkg::OP_OUT: begin
                r_out_is  <= r_func == pwve_pkg::FN_TICK;
                r_out_dac <= (r_func == pwve_pkg::FN_TICK) ? w_dac : '0;
                r_out_vi  <= (r_func == pwve_pkg::FN_TICK) ? '0 : 3'(r_nvoice);
            end
            default: ;
        endcase
    end

    // wavetable memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pwve_pkg::OP_TABLE_WR && 32'(r_taddr) < DEPTH)
            r_mem[AW'(r_taddr)] <= r_tval;
        r_rdata <= r_mem[w_raddr];
    end

    assign o_sts.func         = r_func;
    assign o_sts.voice_active = w_act;
    assign o_sts.voice_drop   = w_drop;
    assign o_sts.last_voice   = w_last;
    assign o_sts.note_ok      = w_note_ok;
    assign o_sts.glide_div    = w_glide && (r_porta > 20'd1);
    assign o_sts.div_done     = w_div_done;
    assign o_sts.out_busy     = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_is_sample   = r_out_is;
    assign o_dac_value   = r_out_dac;
    assign o_voice_index = r_out_vi;

endmodule

[rtl/pwve_ctrl.sv]
`timescale 1ns / 1ps
`include "polyphonic_wavetable_voice_engine_macros.svh"
module pwve_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pwve_pkg::t_sts i_sts,
    output pwve_pkg::t_cmd o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DECODE   = 16'h0002,
        S_GLIDE    = 16'h0004,
        S_PHASE    = 16'h0008,
        S_RD0      = 16'h0010,
        S_RD1      = 16'h0020,
        S_INTERP   = 16'h0040,
        S_MUL1     = 16'h0080,
        S_MUL2     = 16'h0100,
        S_ACC      = 16'h0200,
        S_SCAN     = 16'h0400,
        S_PICK     = 16'h0800,
        S_NOTE     = 16'h1000,
        S_DIV      = 16'h2000,
        S_NOTE_END = 16'h4000,
        S_OUT      = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   w_auto;

    assign w_auto     = i_sts.func == pwve_pkg::FN_NOTE_AUTO;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = pwve_pkg::OP_NONE;
        o_cmd.ptr_inc = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = pwve_pkg::OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    pwve_pkg::FN_TICK: begin
                        o_cmd.op = pwve_pkg::OP_TICK_INIT;
                        n_state  = S_GLIDE;
                    end
                    pwve_pkg::FN_NOTE_ON: begin
                        o_cmd.op = pwve_pkg::OP_NOTE_SEL;
                        n_state  = i_sts.note_ok ? S_NOTE : S_IDLE;
                    end
                    pwve_pkg::FN_NOTE_AUTO: begin
                        o_cmd.op = pwve_pkg::OP_SCAN_INIT;
                        n_state  = S_SCAN;
                    end
                    pwve_pkg::FN_NOTE_OFF: begin
                        o_cmd.op = pwve_pkg::OP_NOTE_OFF;
                        n_state  = S_IDLE;
                    end
                    pwve_pkg::FN_GROUP_OFF: begin
                        o_cmd.op = pwve_pkg::OP_GROUP_OFF;
                        n_state  = S_IDLE;
                    end
                    pwve_pkg::FN_TABLE_WR: begin
                        o_cmd.op = pwve_pkg::OP_TABLE_WR;
                        n_state  = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_GLIDE: begin
                o_cmd.op = pwve_pkg::OP_GLIDE;
                if (!i_sts.voice_active) begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = i_sts.last_voice ? S_OUT : S_GLIDE;
                end else begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: begin
                o_cmd.op = pwve_pkg::OP_PHASE;
                if (i_sts.voice_drop) begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = i_sts.last_voice ? S_OUT : S_GLIDE;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.op = pwve_pkg::OP_RD0;
                n_state  = S_RD1;
            end
            S_RD1: begin
                o_cmd.op = pwve_pkg::OP_RD1;
                n_state  = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.op = pwve_pkg::OP_INTERP;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = pwve_pkg::OP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = pwve_pkg::OP_MUL2;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op      = pwve_pkg::OP_ACC;
                o_cmd.ptr_inc = 1'b1;
                n_state       = i_sts.last_voice ? S_OUT : S_GLIDE;
            end
            S_SCAN: begin
                o_cmd.op      = pwve_pkg::OP_SCAN;
                o_cmd.ptr_inc = 1'b1;
                n_state       = i_sts.last_voice ? S_PICK : S_SCAN;
            end
            S_PICK: begin
                o_cmd.op = pwve_pkg::OP_PICK;
                n_state  = S_NOTE;
            end
            S_NOTE: begin
                o_cmd.op = pwve_pkg::OP_NOTE_START;
                if (i_sts.glide_div)
                    n_state = S_DIV;
                else
                    n_state = w_auto ? S_OUT : S_IDLE;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_NOTE_END;
            end
            S_NOTE_END: begin
                o_cmd.op = pwve_pkg::OP_NOTE_END;
                n_state  = w_auto ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = pwve_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PWVE_ASSERT_NEXT(a_load_decode, (r_state == S_IDLE) && i_in_valid, r_state == S_DECODE, "transaction not decoded")
    `PWVE_ASSERT_NEXT(a_div_end, (r_state == S_DIV) && i_sts.div_done, r_state == S_NOTE_END, "glide step not written")
    `PWVE_ASSERT_SAME(a_out_free, o_cmd.op == pwve_pkg::OP_OUT, !i_sts.out_busy && (r_state == S_OUT), "result overwrote pending one")

endmodule

[rtl/polyphonic_wavetable_voice_engine.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    func, voice, increment, amplitude, wave,
//                                                  group, table address and value
// output    out        o_out_valid / i_out_ready  is_sample, dac_value, voice_index
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// one transaction at a time; a tick visits every voice: an idle voice is skipped at
// glide, a voice that finishes its fade-out is dropped at phase, and a sounding voice
// runs glide, phase, table reads, interpolation, multiplies and accumulate; note on
// waits on the divider for a glide step; automatic note on adds a scan of every voice
// and a pick; results wait in an output register while i_out_ready is low
// synchronous active-low reset; wavetable contents are not cleared
module polyphonic_wavetable_voice_engine #(
    parameter int VOICES     = pwve_pkg::VOICES,
    parameter int TABLE_SIZE = pwve_pkg::TABLE_SIZE,
    parameter int WAVE_COUNT = pwve_pkg::WAVE_COUNT,
    parameter int FADE_STEPS = pwve_pkg::FADE_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_func,
    input  logic [2:0]         i_voice,
    input  logic [31:0]        i_phase_increment,
    input  logic [11:0]        i_amplitude,
    input  logic [1:0]         i_wave,
    input  logic [7:0]         i_group_id,
    input  logic [9:0]         i_table_address,
    input  logic signed [12:0] i_table_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_is_sample,
    output logic [11:0]        o_dac_value,
    output logic [2:0]         o_voice_index,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    pwve_pkg::t_cmd w_cmd;
    pwve_pkg::t_sts w_sts;

    pwve_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    pwve_dp #(
        .VOICES    (VOICES),
        .TABLE_SIZE(TABLE_SIZE),
        .WAVE_COUNT(WAVE_COUNT),
        .FADE_STEPS(FADE_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_voice          (i_voice),
        .i_phase_increment(i_phase_increment),
        .i_amplitude      (i_amplitude),
        .i_wave           (i_wave),
        .i_group_id       (i_group_id),
        .i_table_address  (i_table_address),
        .i_table_value    (i_table_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_is_sample      (o_is_sample),
        .o_dac_value      (o_dac_value),
        .o_voice_index    (o_voice_index)
    );

endmodule
